// ===== design/bts_pkg.sv =====
// ----------------------------------------------------------------------------
// bts_pkg
// Types and constants for the byte translate / delete / squeeze filter.
// ----------------------------------------------------------------------------
package bts_pkg;

    localparam int BYTE_W    = 8;
    localparam int TBL_DEPTH = 256;

    localparam logic [1:0] ACT_DATA  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic CFG_DELETE_MODE  = 1'b0;
    localparam logic CFG_SQUEEZE_MODE = 1'b1;

    typedef struct packed {
        logic [1:0]        action;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] mapped_byte;
        logic              delete_mark;
        logic              squeeze_mark;
    } t_in_word;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
    } t_out_word;

    typedef struct packed {
        logic index;
        logic value;
    } t_cfg_word;

    typedef struct packed {
        logic              en;
        logic [BYTE_W-1:0] addr;
        logic [BYTE_W-1:0] mapped;
        logic              del;
        logic              sqz;
    } t_tbl_wr;

    typedef struct packed {
        logic              en;
        logic [BYTE_W-1:0] addr;
    } t_tbl_rd;

endpackage

// ===== design/bts_intf.sv =====
// ----------------------------------------------------------------------------
// bts_intf
// Valid/ready channels for input words, result words and register writes.
// ----------------------------------------------------------------------------
interface bts_in_if;
    import bts_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bts_out_if;
    import bts_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bts_cfg_if;
    import bts_pkg::*;
    logic      valid;
    logic      ready;
    t_cfg_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/bts_table.sv =====
// ----------------------------------------------------------------------------
// bts_table
// Character table: map/delete memory and squeeze-mark memory, one write
// port shared, one registered read port each.
// ----------------------------------------------------------------------------
module bts_table (
    input  logic              i_clk,
    input  bts_pkg::t_tbl_wr  i_wr,
    input  bts_pkg::t_tbl_rd  i_rd_ent,
    input  bts_pkg::t_tbl_rd  i_rd_sqz,
    output logic [7:0]        o_mapped,
    output logic              o_del,
    output logic              o_sqz
);
    import bts_pkg::*;

    logic [BYTE_W:0]   r_ent_mem [TBL_DEPTH];
    logic              r_sqz_mem [TBL_DEPTH];
    logic [BYTE_W:0]   r_ent_q;
    logic              r_sqz_q;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_ent_mem[i_wr.addr] <= {i_wr.del, i_wr.mapped};
            r_sqz_mem[i_wr.addr] <= i_wr.sqz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_ent.en) begin
            r_ent_q <= r_ent_mem[i_rd_ent.addr];
        end
        if (i_rd_sqz.en) begin
            r_sqz_q <= r_sqz_mem[i_rd_sqz.addr];
        end
    end

    assign o_mapped = r_ent_q[BYTE_W-1:0];
    assign o_del    = r_ent_q[BYTE_W];
    assign o_sqz    = r_sqz_q;

endmodule

// ===== design/byte_translate_delete_squeeze_core.sv =====
// ----------------------------------------------------------------------------
// byte_translate_delete_squeeze_core
// Table-driven byte filter: delete, translate, squeeze repeated output.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                          handshake
//  i_in      in   action, data_byte, mapped_byte, delete/sqz mark  valid/ready
//  o_out     out  out_byte                                         valid/ready
//  i_cfg     in   index, value (delete_mode, squeeze_mode)         valid/ready
//
//  One word per cycle unless o_out stalls; a result passes stage 1, stage 2
//  and the output register on its way to o_out. The two dependent table reads
//  (entry at the byte, squeeze mark at the result byte) set the stage count.
//  Reset clears stage valids, history and modes; the table is not cleared.
//  Words that yield no result retire even while the output register stalls.
// ----------------------------------------------------------------------------
module byte_translate_delete_squeeze_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bts_in_if.sink    i_in,
    bts_out_if.source o_out,
    bts_cfg_if.sink   i_cfg
);
    import bts_pkg::*;

    logic              r_delete_mode;
    logic              r_squeeze_mode;

    logic              r_s1_v;
    logic [1:0]        r_s1_act;
    logic [BYTE_W-1:0] r_s1_byte;

    logic              r_s2_v;
    logic              r_s2_data;
    logic              r_s2_clear;
    logic [BYTE_W-1:0] r_s2_byte;

    logic              r_out_v;
    logic [BYTE_W-1:0] r_out_byte;

    logic              r_prev_v;
    logic [BYTE_W-1:0] r_prev_byte;

    logic              in_ready;
    logic              in_acc;
    logic              s1_adv;
    logic              s2_adv;
    logic              s2_emit;
    logic              sqz_hit;
    logic              s1_drop;
    logic [BYTE_W-1:0] s1_res;

    t_tbl_wr           tbl_wr;
    t_tbl_rd           tbl_rd_ent;
    t_tbl_rd           tbl_rd_sqz;
    logic [BYTE_W-1:0] tbl_mapped;
    logic              tbl_del;
    logic              tbl_sqz;

    assign in_acc = i_in.valid && in_ready;

    assign tbl_wr.en     = in_acc && (i_in.data.action == ACT_WRITE);
    assign tbl_wr.addr   = i_in.data.data_byte;
    assign tbl_wr.mapped = i_in.data.mapped_byte;
    assign tbl_wr.del    = i_in.data.delete_mark;
    assign tbl_wr.sqz    = i_in.data.squeeze_mark;

    assign tbl_rd_ent.en   = in_ready;
    assign tbl_rd_ent.addr = i_in.data.data_byte;

    assign s1_drop = r_delete_mode && tbl_del;
    assign s1_res  = r_delete_mode ? r_s1_byte : tbl_mapped;

    assign tbl_rd_sqz.en   = s1_adv;
    assign tbl_rd_sqz.addr = s1_res;

    bts_table u_table (
        .i_clk    (i_clk),
        .i_wr     (tbl_wr),
        .i_rd_ent (tbl_rd_ent),
        .i_rd_sqz (tbl_rd_sqz),
        .o_mapped (tbl_mapped),
        .o_del    (tbl_del),
        .o_sqz    (tbl_sqz)
    );

    assign sqz_hit  = r_squeeze_mode && tbl_sqz && r_prev_v && (r_prev_byte == r_s2_byte);
    assign s2_emit  = r_s2_v && r_s2_data && !sqz_hit;
    assign s2_adv   = !s2_emit || !r_out_v || o_out.ready;
    assign s1_adv   = !r_s2_v || s2_adv;
    assign in_ready = !r_s1_v || s1_adv;

    assign i_in.ready          = in_ready;
    assign o_out.valid         = r_out_v;
    assign o_out.data.out_byte = r_out_byte;
    assign i_cfg.ready         = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delete_mode  <= 1'b0;
            r_squeeze_mode <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.index)
                CFG_DELETE_MODE:  r_delete_mode  <= i_cfg.data.value;
                CFG_SQUEEZE_MODE: r_squeeze_mode <= i_cfg.data.value;
            endcase
        end
    end

    // stage 1: entry read at the input byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (in_ready) begin
            r_s1_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready) begin
            r_s1_act  <= i_in.data.action;
            r_s1_byte <= i_in.data.data_byte;
        end
    end

    // stage 2: squeeze mark read at the result byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (s1_adv) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s2_data  <= (r_s1_act == ACT_DATA) && !s1_drop;
            r_s2_clear <= (r_s1_act == ACT_CLEAR);
            r_s2_byte  <= s1_res;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (s2_emit && s2_adv) begin
            r_out_v <= 1'b1;
        end else if (o_out.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_emit && s2_adv) begin
            r_out_byte <= r_s2_byte;
        end
    end

    // history of the last emitted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_v    <= 1'b0;
            r_prev_byte <= '0;
        end else if (r_s2_v && s2_adv) begin
            if (r_s2_clear) begin
                r_prev_v <= 1'b0;
            end else if (s2_emit) begin
                r_prev_v    <= 1'b1;
                r_prev_byte <= r_s2_byte;
            end
        end
    end

endmodule
